// ===== rtl/core/mcfp_pkg.sv =====
// Shared types and constants for the motor command frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mcfp_pkg;

	// Default longest frame, in bytes.
	localparam int MAX_FRAME_DEF = 16;

	// Register map and reset value.
	localparam int          PADDR_W     = 3;
	localparam logic        REG_PWM_MAX = 1'b0;
	localparam logic [14:0] PWM_MAX_RST = 15'd1000;

	// Scan phases of the current number.
	localparam logic [1:0] PH_SPACE = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	// Field indexes.
	localparam logic [1:0] FLD_LEFT  = 2'd0;
	localparam logic [1:0] FLD_RIGHT = 2'd1;
	localparam logic [1:0] FLD_BRAKE = 2'd2;

	// Characters of interest.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Magnitude saturation point of the accumulator.
	localparam logic [15:0] ACC_SAT = 16'hFFFF;

	// Parser state carried from byte to byte within a frame.
	typedef struct packed {
		logic [1:0]  field_idx;
		logic [1:0]  phase;
		logic        neg;
		logic [15:0] accum;
		logic        first_neg;
		logic [15:0] first_mag;
		logic        second_neg;
		logic [15:0] second_mag;
		logic        err;
		logic        ended;
	} scan_st_t;

	// Frame result.
	typedef struct packed {
		logic        ok;
		logic [15:0] left;
		logic [15:0] right;
		logic        brake;
	} frame_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/mcfp_step.sv =====
// One byte step of the frame parser: next scan state and the frame result.
// Purely combinational; depends on mcfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcfp_step
	import mcfp_pkg::*;
(
	input  wire scan_st_t   cur,
	input  wire logic [7:0] byte_in,
	input  wire logic       last,
	input  wire logic [14:0] pwm_max,
	output scan_st_t        nxt,
	output frame_res_t      res
);

	logic        is_digit;
	logic        is_space;
	logic [3:0]  dval;
	logic [19:0] prod;
	logic        brake_ok;
	logic        left_ok;
	logic        right_ok;

	assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign is_space = (byte_in == CH_SPACE) || ((byte_in >= CH_TAB) && (byte_in <= CH_CR));
	assign dval     = byte_in[3:0];
	// Times ten as two shifts and an add, then the new digit.
	assign prod     = {1'b0, cur.accum, 3'b000} + {3'b000, cur.accum, 1'b0} + {16'd0, dval};

	// Scan the byte, then check that the text is complete on the last byte.
	always_comb begin
		nxt = cur;
		if (!cur.err && !cur.ended) begin
			if (byte_in == CH_NUL) begin
				nxt.ended = 1'b1;
				if (cur.field_idx != FLD_BRAKE || cur.phase != PH_DIGIT) begin
					nxt.err = 1'b1;
				end
			end else if (cur.phase == PH_SPACE && is_space) begin
				nxt.phase = PH_SPACE;
			end else if (cur.phase == PH_SPACE &&
					(byte_in == CH_PLUS || byte_in == CH_MINUS)) begin
				nxt.neg   = (byte_in == CH_MINUS);
				nxt.phase = PH_SIGN;
			end else if (cur.phase != PH_DIGIT) begin
				if (is_digit) begin
					nxt.accum = {12'd0, dval};
					nxt.phase = PH_DIGIT;
				end else begin
					nxt.err = 1'b1;
				end
			end else if (is_digit) begin
				nxt.accum = (prod > {4'd0, ACC_SAT}) ? ACC_SAT : prod[15:0];
			end else if (byte_in == CH_COMMA && cur.field_idx != FLD_BRAKE) begin
				if (cur.field_idx == FLD_LEFT) begin
					nxt.first_mag = cur.accum;
					nxt.first_neg = cur.neg;
				end else begin
					nxt.second_mag = cur.accum;
					nxt.second_neg = cur.neg;
				end
				nxt.field_idx = cur.field_idx + 2'd1;
				nxt.phase     = PH_SPACE;
				nxt.neg       = 1'b0;
				nxt.accum     = 16'd0;
			end else begin
				nxt.err = 1'b1;
			end
		end
		if (last && !nxt.err && !nxt.ended) begin
			if (nxt.field_idx != FLD_BRAKE || nxt.phase != PH_DIGIT) begin
				nxt.err = 1'b1;
			end
		end
	end

	// Range checks: a drive magnitude within pwm_max, brake zero or plus one.
	assign left_ok  = nxt.first_mag  <= {1'b0, pwm_max};
	assign right_ok = nxt.second_mag <= {1'b0, pwm_max};
	assign brake_ok = (nxt.accum == 16'd0) || (nxt.accum == 16'd1 && !nxt.neg);

	always_comb begin
		res.ok    = !nxt.err && left_ok && right_ok && brake_ok;
		res.left  = 16'd0;
		res.right = 16'd0;
		res.brake = 1'b0;
		if (res.ok) begin
			res.left  = nxt.first_neg  ? (16'd0 - nxt.first_mag)  : nxt.first_mag;
			res.right = nxt.second_neg ? (16'd0 - nxt.second_mag) : nxt.second_mag;
			res.brake = (nxt.accum == 16'd1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/motor_command_frame_parser.sv =====
// Top level of the motor command frame parser: input register, frame state,
// result register and the configuration port. Depends on mcfp_pkg, mcfp_step.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// The input channel (in_valid/in_ready) moves one frame byte per transfer,
// with frame_last on the final byte. Each frame gives exactly one transfer on
// the output channel (out_valid/out_ready): frame_ok and, when it is set,
// left_drive, right_drive and brake_on; on a rejected frame they are zero.
// Throughput is one byte per cycle while no last byte waits for a pending
// result. A byte is registered at its transfer and parsed from the input
// register against the frame state; the result of a frame is registered when
// its last byte leaves the input register.
// While a result waits, later bytes that are not a last byte keep flowing;
// a second last byte waits in the input register until the receiver takes
// the pending result, and in_ready drops while it waits.
// Reset clears the frame state and both channels and sets pwm_max to 1000.
// pwm_max is written over the APB-style port at address 0 and must only be
// changed while no frame is in flight.
module motor_command_frame_parser
	import mcfp_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Byte input
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         frame_byte,
	input  wire logic               frame_last,
	// Result output
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    frame_ok,
	output logic signed [15:0]      left_drive,
	output logic signed [15:0]      right_drive,
	output logic                    brake_on,
	// Configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int CW = $clog2(MAX_FRAME + 2);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAME);

	logic [14:0]   pwm_max_q;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	scan_st_t      st_q;
	scan_st_t      st_in;
	scan_st_t      st_nxt;
	frame_res_t    res;
	logic          out_free;
	logic          fire_s1;

	// Configuration port: one register, writes beyond it are dropped.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_max_q <= PWM_MAX_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_PWM_MAX) begin
			pwm_max_q <= pwdata[14:0];
		end
	end
	assign prdata = (paddr[2] == REG_PWM_MAX) ? {17'd0, pwm_max_q} : 32'd0;

	// Stage one advances unless it holds a last byte and the result is still waiting.
	assign out_free = !out_valid || out_ready;
	assign fire_s1  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= frame_byte;
			last_s1 <= frame_last;
		end
	end

	// Byte count saturates just past the limit; an overlong frame is rejected.
	assign count_nxt = (count_q <= MAX_C) ? count_q + CW'(1) : count_q;
	always_comb begin
		st_in = st_q;
		if (count_nxt > MAX_C) begin
			st_in.err = 1'b1;
		end
	end

	mcfp_step u_step (
		.cur     (st_in),
		.byte_in (byte_s1),
		.last    (last_s1),
		.pwm_max (pwm_max_q),
		.nxt     (st_nxt),
		.res     (res)
	);

	// Frame state: updated per byte, cleared after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			st_q    <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				count_q <= '0;
				st_q    <= '0;
			end else begin
				count_q <= count_nxt;
				st_q    <= st_nxt;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			frame_ok    <= res.ok;
			left_drive  <= res.left;
			right_drive <= res.right;
			brake_on    <= res.brake;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mcfp_checker.sv =====
// Port-level checks for the motor command frame parser, bound to the top.
// Depends on mcfp_pkg and motor_command_frame_parser.
`timescale 1ns / 1ps
`default_nettype none

module mcfp_checker
	import mcfp_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               frame_last,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               frame_ok,
	input wire logic signed [15:0] left_drive,
	input wire logic signed [15:0] right_drive,
	input wire logic               brake_on,
	input wire logic               pready
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_ok) &&
			$stable(left_drive) && $stable(right_drive) && $stable(brake_on))
		else $error("stalled result changed");

	// A rejected frame shows zero drive and no brake.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_ok |-> left_drive == 16'sd0 && right_drive == 16'sd0 &&
			!brake_on)
		else $error("rejected frame with nonzero payload");

	// An accepted drive never reaches the most negative code.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ok |-> left_drive != 16'sh8000 && right_drive != 16'sh8000)
		else $error("drive value out of range");

	// A last byte in the input register with the output free moves to the result register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && frame_last ##1 (!out_valid || out_ready) |=> out_valid)
		else $error("result missing after last byte");

	// The configuration port never waits.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind motor_command_frame_parser mcfp_checker u_mcfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.frame_last  (frame_last),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.frame_ok    (frame_ok),
	.left_drive  (left_drive),
	.right_drive (right_drive),
	.brake_on    (brake_on),
	.pready      (pready)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the motor command frame parser.
// Needs mcfp_pkg and motor_command_frame_parser. Directed frames come first,
// then random frames under several pwm_max settings, all checked in order.
`timescale 1ns / 1ps

module testbench;
	import mcfp_pkg::*;

	localparam int FRAME_MAX    = MAX_FRAME_DEF;
	localparam int GAP_MAX      = 16;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 3000;
	localparam int RANDOM_BYTES = 300;
	localparam int PHASES       = 4;
	localparam int REPORT_MAX   = 10;
	localparam logic [PADDR_W-1:0] ADDR_PWM_MAX = PADDR_W'(4 * int'(REG_PWM_MAX));

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		string      text;
		bit         typed;
		frame_res_t res;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         frame_byte;
	logic               frame_last;
	logic               out_valid;
	logic               out_ready;
	logic               frame_ok;
	logic signed [15:0] left_drive;
	logic signed [15:0] right_drive;
	logic               brake_on;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Our copy of the configuration and of the frame being parsed.
	logic [14:0] pwm_limit;
	int          byte_cnt;
	logic [1:0]  fld;
	logic [1:0]  scan_ph;
	bit          neg;
	int          accum;
	int          left_val;
	int          right_val;
	bit          err;
	bit          ended;

	frame_res_t  expected_cmds[$];
	dir_row_t    dir_rows[$];
	bit          typed_pending;
	frame_res_t  typed_res;
	int          mismatches;
	int          idle_cycles;
	bit          send_calm;
	bit          recv_calm;
	bit          long_hold;

	motor_command_frame_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frame_byte (frame_byte),
		.frame_last (frame_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_ok   (frame_ok),
		.left_drive (left_drive),
		.right_drive(right_drive),
		.brake_on   (brake_on),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Signed value of the number currently being scanned.
	function automatic int signed_accum();
		return neg ? -accum : accum;
	endfunction

	function automatic bit in_drive_range(int v);
		return v >= -int'(pwm_limit) && v <= int'(pwm_limit);
	endfunction

	// Per-item wait, with occasional stretches of back-to-back transfers.
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		return calm ? 0 : int'($urandom_range(0, GAP_MAX));
	endfunction

	task automatic note_mismatch(string what);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch: %s", what);
	endtask

	task automatic clear_frame_state();
		byte_cnt  = 0;
		fld       = FLD_LEFT;
		scan_ph   = PH_SPACE;
		neg       = 1'b0;
		accum     = 0;
		left_val  = 0;
		right_val = 0;
		err       = 1'b0;
		ended     = 1'b0;
	endtask

	// End of text: the brake number must be complete at this point.
	task automatic close_text();
		ended = 1'b1;
		if (fld != FLD_BRAKE || scan_ph != PH_DIGIT)
			err = 1'b1;
	endtask

	// One character of the strtol-style scan.
	task automatic scan_char(logic [7:0] c);
		bit digit;
		int d;
		digit = c >= CH_ZERO && c <= CH_NINE;
		d = int'(c) - int'(CH_ZERO);
		if (c == CH_NUL) begin
			close_text();
			return;
		end
		if (scan_ph == PH_SPACE) begin
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
				return;
			if (c == CH_PLUS || c == CH_MINUS) begin
				neg = (c == CH_MINUS);
				scan_ph = PH_SIGN;
				return;
			end
		end
		if (scan_ph != PH_DIGIT) begin
			if (digit) begin
				accum = d;
				scan_ph = PH_DIGIT;
			end else begin
				err = 1'b1;
			end
			return;
		end
		if (digit) begin
			accum = accum * 10 + d;
			if (accum > int'(ACC_SAT))
				accum = int'(ACC_SAT);
		end else if (c == CH_COMMA && fld != FLD_BRAKE) begin
			if (fld == FLD_LEFT)
				left_val = signed_accum();
			else
				right_val = signed_accum();
			fld++;
			scan_ph = PH_SPACE;
			neg = 1'b0;
			accum = 0;
		end else begin
			err = 1'b1;
		end
	endtask

	// Advances the frame state by one accepted byte; a last byte yields a command.
	task automatic parse_frame_byte(logic [7:0] c, logic last);
		frame_res_t r;
		int brake_val;
		bit ok;
		if (byte_cnt <= FRAME_MAX)
			byte_cnt++;
		if (byte_cnt > FRAME_MAX)
			err = 1'b1;
		if (!err && !ended)
			scan_char(c);
		if (last) begin
			if (!err && !ended)
				close_text();
			brake_val = signed_accum();
			ok = !err && in_drive_range(left_val) && in_drive_range(right_val) &&
				(brake_val == 0 || brake_val == 1);
			r.ok    = ok;
			r.left  = ok ? 16'(left_val) : 16'd0;
			r.right = ok ? 16'(right_val) : 16'd0;
			r.brake = ok && brake_val == 1;
			// A directed row with a typed result replaces the computed one.
			if (typed_pending) begin
				r = typed_res;
				typed_pending = 1'b0;
			end
			expected_cmds.push_back(r);
			clear_frame_state();
		end
	endtask

	// Offers one byte from a falling edge and waits for its transfer.
	task automatic push_byte(logic [7:0] c, logic last);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		frame_byte = c;
		frame_last = last;
		do
			@(posedge clk);
		while (!in_ready);
		parse_frame_byte(c, last);
		@(negedge clk);
	endtask

	task automatic send_frame(byte_q_t fb);
		foreach (fb[i])
			push_byte(fb[i], i == fb.size() - 1);
	endtask

	// In directed text, '~' stands for a zero byte.
	function automatic byte_q_t text_bytes(string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i] == "~" ? CH_NUL : 8'(s[i]));
		return q;
	endfunction

	function automatic string pick_space();
		case ($urandom_range(0, 5))
			0: return " ";
			1: return "\t";
			2: return "\n";
			3: return "\013";
			4: return "\014";
			default: return "\015";
		endcase
	endfunction

	// Drive value text, weighted toward the pwm_max boundaries.
	function automatic string drive_text();
		int v;
		string s;
		s = "";
		if ($urandom_range(0, 3) == 0)
			s = pick_space();
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = int'(pwm_limit);
			2: v = -int'(pwm_limit);
			3: v = int'(pwm_limit) + 1;
			4: v = -int'(pwm_limit) - 1;
			5: v = int'($urandom_range(32768, 9999999));
			default: v = int'($urandom_range(0, 2 * int'(pwm_limit))) - int'(pwm_limit);
		endcase
		if ($urandom_range(0, 1) == 0 && v > 32767)
			v = -v;
		if (v < 0) begin
			s = {s, "-"};
			v = -v;
		end else if ($urandom_range(0, 3) == 0) begin
			s = {s, "+"};
		end
		return {s, $sformatf("%0d", v)};
	endfunction

	function automatic string brake_text();
		case ($urandom_range(0, 7))
			0: return "0";
			1: return "1";
			2: return "-0";
			3: return "+1";
			4: return "2";
			5: return "-1";
			6: return {pick_space(), "1"};
			default: return $sformatf("%0d", $urandom_range(0, 99));
		endcase
	endfunction

	// Mostly well-formed frames; some corrupted, cut short, or pure noise.
	function automatic byte_q_t random_frame();
		byte_q_t q;
		int n;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 20);
			repeat (n) q.push_back(8'($urandom_range(0, 255)));
			return q;
		end
		q = text_bytes({drive_text(), ",", drive_text(), ",", brake_text()});
		case ($urandom_range(0, 8))
			6: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
			7: begin
				q.insert($urandom_range(0, q.size()), CH_NUL);
				repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
			end
			8: begin
				n = $urandom_range(1, q.size() - 1);
				repeat (n) void'(q.pop_back());
			end
			default: ;
		endcase
		return q;
	endfunction

	// APB write of pwm_max, then a read back of the register.
	task automatic write_pwm_max(logic [14:0] v);
		logic [31:0] w;
		w = {17'($urandom), v};
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_PWM_MAX;
		pwdata  = w;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		pwm_limit = w[14:0];
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {17'd0, pwm_limit})
			note_mismatch($sformatf("pwm_max read expected %0d, got %0d", pwm_limit, prdata));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Holds in_valid low and waits until every command has come out.
	task automatic wait_drained();
		in_valid = 1'b0;
		while (expected_cmds.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic add_row(string text, bit typed, bit ok, int l, int r, bit b);
		dir_row_t row;
		row.text      = text;
		row.typed     = typed;
		row.res.ok    = ok;
		row.res.left  = 16'(l);
		row.res.right = 16'(r);
		row.res.brake = b;
		dir_rows.push_back(row);
	endtask

	// Receiver: random stalls, one long hold-off on request, in-order checking.
	initial begin
		int stall;
		frame_res_t exp_cmd;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				stall = HOLD_CYCLES;
				long_hold = 1'b0;
			end else begin
				stall = draw_gap(recv_calm);
			end
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			if (expected_cmds.size() == 0) begin
				note_mismatch($sformatf("unexpected result ok=%0d left=%0d right=%0d brake=%0d",
					frame_ok, left_drive, right_drive, brake_on));
			end else begin
				exp_cmd = expected_cmds.pop_front();
				if (frame_ok !== exp_cmd.ok || left_drive !== exp_cmd.left ||
					right_drive !== exp_cmd.right || brake_on !== exp_cmd.brake)
					note_mismatch($sformatf(
						"expected ok=%0d left=%0d right=%0d brake=%0d, got %0d %0d %0d %0d",
						exp_cmd.ok, $signed(exp_cmd.left), $signed(exp_cmd.right),
						exp_cmd.brake, frame_ok, left_drive, right_drive, brake_on));
			end
			@(negedge clk);
		end
	end

	// Watchdog on cycles with no transfer on any port.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [14:0] settings [PHASES];
		int sent;
		byte_q_t fb;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		frame_byte    = 8'd0;
		frame_last    = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = 32'd0;
		idle_cycles   = 0;
		mismatches    = 0;
		typed_pending = 1'b0;
		long_hold     = 1'b0;
		send_calm     = 1'b0;
		recv_calm     = 1'b0;
		pwm_limit     = PWM_MAX_RST;
		clear_frame_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames at the reset value of pwm_max.
		add_row("0,0,0", 1, 1, 0, 0, 1'b0);
		add_row("1000,-1000,1", 1, 1, 1000, -1000, 1'b1);
		add_row("-1000,+1000,0", 1, 1, -1000, 1000, 1'b0);
		add_row("1001,0,0", 1, 0, 0, 0, 1'b0);
		add_row("0,-1001,1", 1, 0, 0, 0, 1'b0);
		add_row("0,0,2", 1, 0, 0, 0, 1'b0);
		add_row("0,0,-1", 1, 0, 0, 0, 1'b0);
		add_row("-0,0,-0", 1, 1, 0, 0, 1'b0);
		add_row("99999999,0,0", 1, 0, 0, 0, 1'b0);
		add_row("1,2", 1, 0, 0, 0, 1'b0);
		add_row(",", 1, 0, 0, 0, 1'b0);
		add_row("7", 1, 0, 0, 0, 1'b0);
		add_row("1,2,1,", 1, 0, 0, 0, 1'b0);
		add_row("1,,1", 1, 0, 0, 0, 1'b0);
		add_row("+,1,1", 1, 0, 0, 0, 1'b0);
		add_row("1 ,2,0", 1, 0, 0, 0, 1'b0);
		add_row("1,2,1 ", 1, 0, 0, 0, 1'b0);
		add_row("1a,2,0", 1, 0, 0, 0, 1'b0);
		add_row("0,0,1~xyz", 1, 1, 0, 0, 1'b1);
		add_row("0,0~,1", 1, 0, 0, 0, 1'b0);
		add_row("000000000001,2,1", 1, 1, 1, 2, 1'b1);
		add_row("0000000000001,2,1", 1, 0, 0, 0, 1'b0);
		add_row("0,0,0~aaaaaaaaaaaaaaa", 1, 0, 0, 0, 1'b0);
		add_row(" \t+5,\n-7,\0131", 0, 0, 0, 0, 1'b0);
		add_row("\014\0150,\0131,\t 0", 0, 0, 0, 0, 1'b0);
		foreach (dir_rows[i]) begin
			typed_pending = dir_rows[i].typed;
			typed_res     = dir_rows[i].res;
			send_frame(text_bytes(dir_rows[i].text));
		end
		wait_drained();

		// Random frames under each pwm_max setting, extremes included.
		settings[0] = 15'd0;
		settings[1] = 15'h7FFF;
		settings[2] = 15'($urandom);
		settings[3] = 15'd1;
		for (int p = 0; p < PHASES; p++) begin
			write_pwm_max(settings[p]);
			if (p == 1)
				long_hold = 1'b1;
			sent = 0;
			while (sent < RANDOM_BYTES / PHASES) begin
				fb = random_frame();
				send_frame(fb);
				sent += fb.size();
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
